[sv/flsi_pkg.sv]
`default_nettype none
package flsi_pkg;

  // header layout
  localparam int unsigned HdrBytes  = 42;
  localparam int unsigned PosW      = 6;
  localparam int unsigned InfoFirst = 18;
  localparam int unsigned InfoLast  = 25;
  localparam int unsigned InfoW     = 64;

  // expected header bytes
  localparam logic [7:0] MagicF     = 8'h66;
  localparam logic [7:0] MagicL     = 8'h4C;
  localparam logic [7:0] MagicA     = 8'h61;
  localparam logic [7:0] MagicC     = 8'h43;
  localparam logic [7:0] TypeMask   = 8'h7F;
  localparam logic [7:0] StreamLen  = 8'd34;

  // field widths
  localparam int unsigned RateW   = 20;
  localparam int unsigned ChanW   = 4;
  localparam int unsigned BitsW   = 6;
  localparam int unsigned FramesW = 36;
  localparam int unsigned DurW    = 32;

  // divider sizing: frames * 1000 fits in 46 bits
  localparam int unsigned MsScaleW  = 10;
  localparam logic [MsScaleW-1:0] MsScale = 10'd1000;
  localparam int unsigned DividendW = FramesW + MsScaleW;
  localparam int unsigned DivCntW   = $clog2(DividendW + 1);

  // queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // one queued job: either a plain failure or a collected info word
  typedef struct packed {
    logic             fail_only;
    logic [InfoW-1:0] info;
  } job_t;

  typedef enum logic {
    BkIdle,
    BkDiv
  } back_state_e;

  function automatic logic byte_ok(input logic [PosW-1:0] pos, input logic [7:0] b);
    logic ok;
    case (pos)
      6'd0:    ok = (b == MagicF);
      6'd1:    ok = (b == MagicL);
      6'd2:    ok = (b == MagicA);
      6'd3:    ok = (b == MagicC);
      6'd4:    ok = ((b & TypeMask) == 8'h00);
      6'd5:    ok = (b == 8'h00);
      6'd6:    ok = (b == 8'h00);
      6'd7:    ok = (b == StreamLen);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage
`default_nettype wire

[sv/flsi_front.sv]
`default_nettype none
module flsi_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           last_byte_i,
  input  wire logic           q_full_i,
  output logic                push_o,
  output flsi_pkg::job_t      push_job_o
);
  import flsi_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic             bad_q, bad_d;
  logic             given_q, given_d;
  logic [InfoW-1:0] info_q, info_d;
  logic             accept;
  logic             active;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign active     = !given_q && (pos_q < PosW'(HdrBytes));

  always_comb begin
    pos_d      = pos_q;
    bad_d      = bad_q;
    given_d    = given_q;
    info_d     = info_q;
    push_o     = 1'b0;
    push_job_o = '{fail_only: 1'b1, info: '0};
    if (accept) begin
      if (active) begin
        if (!byte_ok(pos_q, data_byte_i)) begin
          bad_d = 1'b1;
        end
        if (pos_q >= PosW'(InfoFirst) && pos_q <= PosW'(InfoLast)) begin
          info_d = {info_q[InfoW-9:0], data_byte_i};
        end
        pos_d = pos_q + 1'b1;
        if (pos_q == PosW'(HdrBytes - 1)) begin
          // bytes past 7 never fail the check, so the held flag is final
          push_o     = 1'b1;
          push_job_o = '{fail_only: bad_q, info: info_q};
          given_d    = 1'b1;
        end else if (last_byte_i) begin
          push_o = 1'b1;
        end
      end
      if (last_byte_i) begin
        pos_d   = '0;
        bad_d   = 1'b0;
        given_d = 1'b0;
        info_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      bad_q   <= 1'b0;
      given_q <= 1'b0;
      info_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      bad_q   <= bad_d;
      given_q <= given_d;
      info_q  <= info_d;
    end
  end

endmodule
`default_nettype wire

[sv/flsi_queue.sv]
`default_nettype none
module flsi_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire flsi_pkg::job_t push_job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output flsi_pkg::job_t      head_o
);
  import flsi_pkg::*;

  job_t              slots_q [QDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QCntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/flsi_back.sv]
`default_nettype none
module flsi_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_empty_i,
  input  wire flsi_pkg::job_t               q_head_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              probe_failed_o,
  output logic [flsi_pkg::RateW-1:0]        sample_rate_o,
  output logic [flsi_pkg::ChanW-1:0]        channel_count_o,
  output logic [flsi_pkg::BitsW-1:0]        sample_bits_o,
  output logic [flsi_pkg::FramesW-1:0]      total_frames_o,
  output logic [flsi_pkg::DurW-1:0]         duration_ms_o
);
  import flsi_pkg::*;

  back_state_e          state_q, state_d;
  logic [InfoW-1:0]     info_q;
  logic [RateW-1:0]     rem_q, rem_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivCntW-1:0]   cnt_q;

  logic                 out_free;
  logic                 start_div, step_div, load_direct, load_quot;

  logic [RateW-1:0]     h_rate, j_rate;
  logic [FramesW-1:0]   h_frames, j_frames;
  logic [ChanW-1:0]     h_chan, j_chan;
  logic [BitsW-1:0]     h_bits, j_bits;
  logic                 needs_div;

  logic [RateW:0]       trial;
  logic [RateW+1:0]     diff;
  logic                 ge;

  logic                 ov_q;
  logic                 pf_q;
  logic [RateW-1:0]     rate_q;
  logic [ChanW-1:0]     chan_q;
  logic [BitsW-1:0]     bits_q;
  logic [FramesW-1:0]   frames_q;
  logic [DurW-1:0]      dur_q;

  // field decode of the queue head and of the held job
  assign h_rate   = q_head_i.info[63:44];
  assign h_chan   = ChanW'(q_head_i.info[43:41]) + 1'b1;
  assign h_bits   = BitsW'(q_head_i.info[40:36]) + 1'b1;
  assign h_frames = q_head_i.info[FramesW-1:0];
  assign j_rate   = info_q[63:44];
  assign j_chan   = ChanW'(info_q[43:41]) + 1'b1;
  assign j_bits   = BitsW'(info_q[40:36]) + 1'b1;
  assign j_frames = info_q[FramesW-1:0];

  assign needs_div = !q_head_i.fail_only && (h_rate != '0) && (h_frames != '0);
  assign out_free  = !ov_q || !out_stall_i;

  // restoring divide, one quotient bit per cycle
  assign trial = {rem_q, quo_q[DividendW-1]};
  assign diff  = {1'b0, trial} - {2'b00, j_rate};
  assign ge    = !diff[RateW+1];
  assign rem_d = ge ? diff[RateW-1:0] : trial[RateW-1:0];
  assign quo_d = {quo_q[DividendW-2:0], ge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle: begin
        if (pop_o && needs_div) begin
          state_d = BkDiv;
        end
      end
      BkDiv: begin
        if (load_quot) begin
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    start_div   = 1'b0;
    step_div    = 1'b0;
    load_direct = 1'b0;
    load_quot   = 1'b0;
    case (state_q)
      BkIdle: begin
        if (!q_empty_i && (needs_div || out_free)) begin
          pop_o       = 1'b1;
          start_div   = needs_div;
          load_direct = !needs_div;
        end
      end
      BkDiv: begin
        if (cnt_q == DivCntW'(DividendW)) begin
          load_quot = out_free;
        end else begin
          step_div = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (load_direct || load_quot) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
      if (start_div) begin
        cnt_q <= '0;
      end else if (step_div) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_div) begin
      info_q <= q_head_i.info;
      rem_q  <= '0;
      quo_q  <= DividendW'(h_frames) * DividendW'(MsScale);
    end else if (step_div) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (load_direct) begin
      if (q_head_i.fail_only) begin
        pf_q     <= 1'b1;
        rate_q   <= '0;
        chan_q   <= '0;
        bits_q   <= '0;
        frames_q <= '0;
      end else begin
        pf_q     <= (h_rate == '0);
        rate_q   <= h_rate;
        chan_q   <= h_chan;
        bits_q   <= h_bits;
        frames_q <= h_frames;
      end
      dur_q <= '0;
    end else if (load_quot) begin
      pf_q     <= 1'b0;
      rate_q   <= j_rate;
      chan_q   <= j_chan;
      bits_q   <= j_bits;
      frames_q <= j_frames;
      dur_q    <= quo_q[DurW-1:0];
    end
  end

  assign out_valid_o     = ov_q;
  assign probe_failed_o  = pf_q;
  assign sample_rate_o   = rate_q;
  assign channel_count_o = chan_q;
  assign sample_bits_o   = bits_q;
  assign total_frames_o  = frames_q;
  assign duration_ms_o   = dur_q;

endmodule
`default_nettype wire

[sv/flac_streaminfo_parser_top.sv]
// flac streaminfo probe: reads a flac file buffer one word (byte) at a time
// input channel: in_valid_i / in_stall_o carry data_byte_i and last_byte_i,
//   last_byte_i marks the final byte of a buffer and rearms the parser
// output channel: out_valid_o / out_stall_i carry one result per buffer,
//   either on the 42nd byte or on an earlier last byte (short buffer)
// the front takes one byte per cycle while the queue has room, checks magic,
//   block type and length, collects the stream info bytes, and puts a result
//   as a job into a 2-deep queue; the back pops jobs and runs a restoring
//   divider for frames*1000/rate; failures, zero rate and zero frames skip it
// path: the front writes a job into a queue slot, and the back loads it into
//   the output registers directly or, with a divide, when the divider is done
// throughput: one byte per cycle while the queue has room; the back takes a
//   new job only after a divide is done and a plain result every cycle while
//   unstalled; in_stall_o rises only when the queue holds two jobs
// a stalled result holds in the output register while the front keeps going
// reset clears the parser, the queue and the output valid; no result is pending
`default_nettype none
module flac_streaminfo_parser_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [7:0]                   data_byte_i,
  input  wire logic                         last_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              probe_failed_o,
  output logic [flsi_pkg::RateW-1:0]        sample_rate_o,
  output logic [flsi_pkg::ChanW-1:0]        channel_count_o,
  output logic [flsi_pkg::BitsW-1:0]        sample_bits_o,
  output logic [flsi_pkg::FramesW-1:0]      total_frames_o,
  output logic [flsi_pkg::DurW-1:0]         duration_ms_o
);
  import flsi_pkg::*;

  // front to queue
  logic push;
  job_t push_job;
  logic q_full;

  // queue to back
  logic q_empty;
  logic pop;
  job_t q_head;

  flsi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_job_o (push_job)
  );

  flsi_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .full_o    (q_full),
    .pop_i     (pop),
    .empty_o   (q_empty),
    .head_o    (q_head)
  );

  flsi_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_head_i       (q_head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .probe_failed_o (probe_failed_o),
    .sample_rate_o  (sample_rate_o),
    .channel_count_o(channel_count_o),
    .sample_bits_o  (sample_bits_o),
    .total_frames_o (total_frames_o),
    .duration_ms_o  (duration_ms_o)
  );

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_full))
    else $error("job pushed into full queue");

  // the back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_empty))
    else $error("job popped from empty queue");

  // a passing result always carries a nonzero rate and decoded format
  a_pass_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !probe_failed_o) |->
      (sample_rate_o != '0 && channel_count_o != '0 && sample_bits_o != '0))
    else $error("passing result with empty fields");

  // a failure with zero rate never reports a duration
  a_fail_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && probe_failed_o) |-> (duration_ms_o == '0))
    else $error("failed result with nonzero duration");

endmodule
`default_nettype wire
